@@ design/toks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toks_pkg: shared constants for the top-k sum tracker
// Widths of the result and configuration words, register indexes and the
// default sizing of the sorted cell chain.
// ----------------------------------------------------------------------------
package toks_pkg;

	localparam int DEF_CAPACITY    = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int SUM_W       = 38;
	localparam int K_W         = 7;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_K_COUNT       = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PICK_SMALLEST = CFG_INDEX_W'(1);

endpackage

@@ design/toks_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toks_cell: one rank of the sorted chain
// Holds one value in ascending rank order, shifts up on insertion and adds
// its value into the partial sum from the cell below if its rank is selected.
// ----------------------------------------------------------------------------
module toks_cell #(
	parameter int CAPACITY    = toks_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = toks_pkg::DEF_VALUE_WIDTH,
	parameter int IDX         = 0
) (
	input  logic                                  clk,
	input  logic                                  ins_en,
	input  logic signed [VALUE_WIDTH-1:0]         ins_value,
	input  logic [$clog2(CAPACITY+1)-1:0]         count,
	input  logic [$clog2(CAPACITY+1)-1:0]         sel_lo,
	input  logic [$clog2(CAPACITY+1)-1:0]         sel_hi,
	input  logic                                  prev_gt,
	input  logic signed [VALUE_WIDTH-1:0]         prev_value,
	input  logic signed [toks_pkg::SUM_W-1:0]     psum_in,
	output logic                                  gt,
	output logic signed [VALUE_WIDTH-1:0]         value_out,
	output logic signed [toks_pkg::SUM_W-1:0]     psum_out
);

	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [VALUE_WIDTH-1:0]     value_q;
	logic signed [toks_pkg::SUM_W-1:0] psum_q;
	logic signed [toks_pkg::SUM_W-1:0] addend;
	logic                              occupied;
	logic                              selected;

	// empty ranks count as greater than anything
	always_comb begin
		occupied = MY_IDX < count;
		gt       = !occupied || (value_q > ins_value);
		selected = (MY_IDX >= sel_lo) && (MY_IDX < sel_hi);
		addend   = selected ? toks_pkg::SUM_W'(value_q) : '0;
	end

	always_ff @(posedge clk) begin
		if (ins_en && gt) begin
			value_q <= prev_gt ? prev_value : ins_value;
		end
		psum_q <= psum_in + addend;
	end

	assign value_out = value_q;
	assign psum_out  = psum_q;

endmodule

@@ design/top_k_sum_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sum_tracker_core: bounded sorted store with a top-k sum
// Inserts each word into a sorted chain of cells while there is room and reports
// the sum of the k largest (or smallest) held values, the fill level and two status flags.
// ----------------------------------------------------------------------------
//  channel | signals                                   | word
//  in      | in_valid, in_stall, value                 | one signed value
//  out     | out_valid, out_stall, top_sum, held_count,| one result
//          | short_flag, overflow_flag                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
//  an input word is inserted into the chain, the rank window is registered
//  and then the partial sum ripples through the register of every cell
//  no input word is taken until the previous result is in the output register
//  reset clears the fill level, the registers and the handshake state
//  a stalled output holds its word; the next sum waits for the register
// ----------------------------------------------------------------------------
module top_k_sum_tracker_core #(
	parameter int CAPACITY    = toks_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = toks_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [VALUE_WIDTH-1:0]         value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [toks_pkg::SUM_W-1:0]     top_sum,
	output logic [$clog2(CAPACITY+1)-1:0]         held_count,
	output logic                                  short_flag,
	output logic                                  overflow_flag,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [toks_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [toks_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CNT_W  = $clog2(CAPACITY+1);
	localparam int CMP_W  = (CNT_W > toks_pkg::K_W) ? CNT_W : toks_pkg::K_W;
	localparam int PASS_W = $clog2(CAPACITY+2);
	localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(CAPACITY+1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SUM  = 1'b1;

	logic                          state_q;
	logic [PASS_W-1:0]             pass_q;
	logic [CNT_W-1:0]              count_q;
	logic [toks_pkg::K_W-1:0]      k_q;
	logic                          pick_q;
	logic                          rejected_q;
	logic [CNT_W-1:0]              sel_lo_q;
	logic [CNT_W-1:0]              sel_hi_q;
	logic                          out_valid_q;
	logic signed [toks_pkg::SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]              held_q;
	logic                          short_q;
	logic                          ovf_q;

	logic                          in_acc;
	logic                          out_acc;
	logic                          cfg_acc;
	logic                          ins_en;
	logic                          out_free;
	logic                          sum_done;
	logic [CMP_W-1:0]              k_ext;
	logic [CMP_W-1:0]              cnt_ext;
	logic [CNT_W-1:0]              take;

	logic                              gt_w    [CAPACITY+1];
	logic signed [VALUE_WIDTH-1:0]     val_w   [CAPACITY+1];
	logic signed [toks_pkg::SUM_W-1:0] psum_w  [CAPACITY+1];

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign ins_en    = in_acc && (count_q < CNT_FULL);
	assign out_free  = !out_valid_q || !out_stall;
	assign sum_done  = (state_q == ST_SUM) && (pass_q == PASS_LAST) && out_free;

	always_comb begin
		k_ext   = CMP_W'(k_q);
		cnt_ext = CMP_W'(count_q);
		take    = (k_ext < cnt_ext) ? CNT_W'(k_q) : count_q;
	end

	// chain boundary
	assign gt_w[0]   = 1'b0;
	assign val_w[0]  = '0;
	assign psum_w[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		toks_cell #(
			.CAPACITY    (CAPACITY),
			.VALUE_WIDTH (VALUE_WIDTH),
			.IDX         (i)
		) u_cell (
			.clk        (clk),
			.ins_en     (ins_en),
			.ins_value  (value),
			.count      (count_q),
			.sel_lo     (sel_lo_q),
			.sel_hi     (sel_hi_q),
			.prev_gt    (gt_w[i]),
			.prev_value (val_w[i]),
			.psum_in    (psum_w[i]),
			.gt         (gt_w[i+1]),
			.value_out  (val_w[i+1]),
			.psum_out   (psum_w[i+1])
		);
	end

	// rank window of the selected values
	always_ff @(posedge clk) begin
		sel_lo_q <= pick_q ? '0 : (count_q - take);
		sel_hi_q <= pick_q ? take : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			pick_q <= 1'b0;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				toks_pkg::REG_K_COUNT:       k_q    <= cfg_data[toks_pkg::K_W-1:0];
				toks_pkg::REG_PICK_SMALLEST: pick_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sum_done) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SUM;
						pass_q  <= '0;
						if (ins_en) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SUM: begin
					if (pass_q != PASS_LAST) begin
						pass_q <= pass_q + PASS_W'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rejected_q <= !ins_en;
		end
		if (sum_done) begin
			sum_q   <= psum_w[CAPACITY];
			held_q  <= count_q;
			short_q <= cnt_ext < k_ext;
			ovf_q   <= rejected_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign top_sum       = sum_q;
	assign held_count    = held_q;
	assign short_flag    = short_q;
	assign overflow_flag = ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("fill level beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("fill level moved by more than one");

	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SUM) && (pass_q == '0))
		else $error("sum pass did not start after insertion");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ovf_q) |-> (held_q == CNT_FULL))
		else $error("rejection reported with room in the store");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for top_k_sum_tracker_core
// Pushes signed words into the sorted store and checks every reported
// top-k sum, fill level, short flag and overflow flag against a behavioural
// model of the store, or against the table's own values for its typed rows.
// A short table of directed words comes first, then random phases under
// changing k and selection mode until the store is full and beyond, with
// random gaps on the input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int CAPACITY     = toks_pkg::DEF_CAPACITY;
	localparam int VW           = toks_pkg::DEF_VALUE_WIDTH;
	localparam int SUM_W        = toks_pkg::SUM_W;
	localparam int K_W          = toks_pkg::K_W;
	localparam int CFG_INDEX_W  = toks_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W   = toks_pkg::CFG_DATA_W;
	localparam int RANDOM_ITEMS = 780;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 500;
	localparam int DIR_ROWS     = 20;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [K_W-1:0]          held;
		logic                    short_f;
		logic                    ovf;
	} sum_report_t;

	typedef struct packed {
		logic [K_W-1:0]          k;
		logic                    pick;
		logic [VW-1:0]           word;
		logic                    typed;
		logic signed [SUM_W-1:0] sum;
		logic [K_W-1:0]          held;
		logic                    short_f;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{7'd0,   1'b0, 32'h7FFFFFFF, 1'b1, 38'sd0,             7'd1,  1'b0},
		'{7'd0,   1'b0, 32'h80000000, 1'b1, 38'sd0,             7'd2,  1'b0},
		'{7'd1,   1'b0, 32'h00000000, 1'b1, 38'sd2147483647,    7'd3,  1'b0},
		'{7'd1,   1'b1, 32'hFFFFFFFF, 1'b1, -38'sd2147483648,   7'd4,  1'b0},
		'{7'd127, 1'b0, 32'h00000001, 1'b1, -38'sd1,            7'd5,  1'b1},
		'{7'd127, 1'b1, 32'h00000001, 1'b1, 38'sd0,             7'd6,  1'b1},
		'{7'd64,  1'b0, 32'h80000000, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd2,   1'b0, 32'h7FFFFFFF, 1'b1, 38'sd4294967294,    7'd8,  1'b0},
		'{7'd2,   1'b1, 32'h80000000, 1'b1, -38'sd4294967296,   7'd9,  1'b0},
		'{7'd3,   1'b1, 32'h80000000, 1'b1, -38'sd6442450944,   7'd10, 1'b0},
		'{7'd5,   1'b0, 32'h12345678, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd5,   1'b0, 32'hDEADBEEF, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd5,   1'b0, 32'h00000000, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd5,   1'b0, 32'h55555555, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd5,   1'b0, 32'hAAAAAAAA, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd64,  1'b1, 32'h7FFFFFFE, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd64,  1'b1, 32'h80000001, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd63,  1'b0, 32'hFFFF0000, 1'b0, 38'sd0,             7'd0,  1'b0},
		'{7'd0,   1'b1, 32'h0000FFFF, 1'b1, 38'sd0,             7'd19, 1'b0},
		'{7'd0,   1'b1, 32'h00010000, 1'b1, 38'sd0,             7'd20, 1'b0}
	};

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic signed [VW-1:0]      value         = '0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic signed [SUM_W-1:0]   top_sum;
	logic [K_W-1:0]            held_count;
	logic                      short_flag;
	logic                      overflow_flag;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index     = '0;
	logic [CFG_DATA_W-1:0]     cfg_data      = '0;

	logic signed [VW-1:0] ranked [CAPACITY];
	int                   ranked_n    = 0;
	logic [K_W-1:0]       model_k     = '0;
	logic                 model_pick  = 1'b0;
	sum_report_t          pending_reports [$];

	int          fails       = 0;
	int          got_reports = 0;
	int unsigned cycles      = 0;
	bit          calm        = 1'b0;
	bit          hold_done   = 1'b0;
	int          hold_left   = 0;

	top_k_sum_tracker_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.top_sum       (top_sum),
		.held_count    (held_count),
		.short_flag    (short_flag),
		.overflow_flag (overflow_flag),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// insert into the sorted copy of the store while it has room and rebuild the selected sum
	function automatic sum_report_t predict_push(input logic signed [VW-1:0] v);
		sum_report_t             r;
		int                      pos;
		int                      take;
		int                      i;
		logic signed [SUM_W-1:0] acc;
		r.ovf = (ranked_n >= CAPACITY);
		if (!r.ovf) begin
			pos = ranked_n;
			while (pos > 0 && ranked[pos-1] > v) begin
				ranked[pos] = ranked[pos-1];
				pos--;
			end
			ranked[pos] = v;
			ranked_n++;
		end
		take = (int'(model_k) < ranked_n) ? int'(model_k) : ranked_n;
		acc = '0;
		for (i = 0; i < take; i++) begin
			if (model_pick)
				acc += ranked[i];
			else
				acc += ranked[ranked_n-1-i];
		end
		r.sum     = acc;
		r.held    = K_W'(ranked_n);
		r.short_f = (ranked_n < int'(model_k));
		return r;
	endfunction

	task automatic push_value(input logic [VW-1:0] v, input bit use_typed,
			input sum_report_t typed_rep);
		sum_report_t r;
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			value <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		r = predict_push(v);
		pending_reports.push_back(use_typed ? typed_rep : r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_word(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == toks_pkg::REG_K_COUNT)
			model_k = data;
		else if (idx == toks_pkg::REG_PICK_SMALLEST)
			model_pick = data[0];
		@(negedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] pick,
			input bit junk);
		drain();
		cfg_word(toks_pkg::REG_K_COUNT, k);
		cfg_word(toks_pkg::REG_PICK_SMALLEST, pick);
		if (junk)
			cfg_word(CFG_INDEX_W'($urandom_range(2, 2**CFG_INDEX_W - 1)), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// receiver side: random stalls, one long hold-off once results flow
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && got_reports >= 150) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !calm && ($urandom_range(99) < 11);
	end

	always @(posedge clk) begin
		sum_report_t e;
		if (arst_n && out_valid && !out_stall) begin
			got_reports++;
			if (pending_reports.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				e = pending_reports.pop_front();
				if (top_sum !== e.sum) begin
					$error("top_sum: expected %0d, got %0d", e.sum, top_sum);
					fails++;
				end
				if (held_count !== e.held) begin
					$error("held_count: expected %0d, got %0d", e.held, held_count);
					fails++;
				end
				if (short_flag !== e.short_f) begin
					$error("short_flag: expected %0d, got %0d", e.short_f, short_flag);
					fails++;
				end
				if (overflow_flag !== e.ovf) begin
					$error("overflow_flag: expected %0d, got %0d", e.ovf, overflow_flag);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL top_k_sum_tracker_core");
			$finish;
		end
	end

	initial begin
		sum_report_t          rep;
		dir_row_t             row;
		int                   sent;
		int                   len;
		logic [K_W-1:0]       k;
		logic signed [VW-1:0] v;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = DIR_TABLE[r];
			if (row.k != model_k || row.pick != model_pick)
				write_regs(row.k, {6'd0, row.pick}, 1'b0);
			rep.sum     = row.sum;
			rep.held    = row.held;
			rep.short_f = row.short_f;
			rep.ovf     = 1'b0;
			push_value(row.word, row.typed, rep);
		end

		// random phases, the store fills and then rejects
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(6))
				0: k = '0;
				1: k = K_W'(CAPACITY);
				2: k = K_W'(CAPACITY - 1);
				3: k = 7'd127;
				4: k = 7'd1;
				default: k = K_W'($urandom_range(CAPACITY));
			endcase
			write_regs(k, CFG_DATA_W'($urandom), $urandom_range(3) == 0);
			len = $urandom_range(10, 60);
			repeat (len) begin
				calm = (sent >= 300 && sent < 420);
				case ($urandom_range(9))
					0: v = {1'b1, {(VW-1){1'b0}}};
					1: v = {1'b0, {(VW-1){1'b1}}};
					2: v = VW'($signed($urandom_range(16)) - 8);
					default: v = $urandom;
				endcase
				push_value(v, 1'b0, '0);
				sent++;
			end
		end
		calm = 1'b0;

		drain();
		repeat (CAPACITY + 8) @(negedge clk);
		if (fails == 0 && pending_reports.size() == 0)
			$display("PASS top_k_sum_tracker_core");
		else
			$display("FAIL top_k_sum_tracker_core");
		$finish;
	end

endmodule
